// ===== rtl/packed_delta_channel_decoder_core_defines.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef PACKED_DELTA_CHANNEL_DECODER_CORE_DEFINES_SVH
`define PACKED_DELTA_CHANNEL_DECODER_CORE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PDCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that a condition never occurs outside reset.
`define PDCD_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// ===== rtl/pdcd_pkg.sv =====
package pdcd_pkg;

    localparam int MAX_SUB_DEFAULT = 15;

    // Remembered width that marks an end code
    localparam logic [4:0] WIDTH_END = 5'd31;

    // Selector codes with special meaning
    localparam logic [3:0] SEL_RAW    = 4'd13;
    localparam logic [3:0] SEL_REPEAT = 4'd14;
    localparam logic [3:0] SEL_END    = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_APPEND,
        ST_FIELD,
        ST_DROP
    } state_t;

    typedef struct packed {
        logic [31:0] data;
        logic [5:0]  amt;
        logic        left;
    } shift_req_t;

    function automatic logic [15:0] bias_of(input logic [3:0] sel);
        logic [15:0] b;
        case (sel)
            4'd1:    b = 16'h0001;
            4'd2:    b = 16'hFFFC;
            4'd3:    b = 16'h0005;
            4'd4:    b = 16'hFFEC;
            4'd5:    b = 16'h0015;
            4'd6:    b = 16'hFFAC;
            4'd7:    b = 16'h0055;
            4'd8:    b = 16'hFEAC;
            4'd9:    b = 16'h0155;
            4'd10:   b = 16'hFAAC;
            4'd11:   b = 16'h0555;
            4'd12:   b = 16'hEAAC;
            default: b = 16'h0000;
        endcase
        return b;
    endfunction

    function automatic logic [15:0] low_mask16(input logic [4:0] n);
        logic [16:0] m;
        m = (17'd1 << n) - 17'd1;
        return m[15:0];
    endfunction

endpackage

// ===== rtl/pdcd_shift_unit.sv =====
module pdcd_shift_unit
    import pdcd_pkg::*;
(
    input  shift_req_t  req,
    output logic [31:0] result
);

    // Shift by 0..31; an amount of 32 or more clears the word
    always_comb begin
        if (req.amt[5]) begin
            result = '0;
        end else if (req.left) begin
            result = req.data << req.amt[4:0];
        end else begin
            result = req.data >> req.amt[4:0];
        end
    end

endmodule

// ===== rtl/packed_delta_channel_decoder_core.sv =====
// Packed delta channel decoder. Feed one channel as bytes on the s_ channel: a header
// transfer (s_first = 1) carries the base value and two stream bits, the following
// transfers carry eight stream bits each, most significant first. Codes are decoded
// one at a time by a small sequencer around a single 32-bit barrel shifter, which
// appends the byte to the bit window, extracts each field and drops consumed bits.
// A header is captured and then loaded into the window. A data byte is first appended
// to the window; then each code that it completes is extracted and its bits dropped,
// until the next code is found incomplete. The byte that closes the channel skips that
// last check. Zero-width repeats can finish all sixteen codes in one byte.
// One result is produced when the channel finishes (first code plus sub_count more,
// or an end mark); a header arriving while a channel is open yields the partial value
// with m_abandoned set. The output register lets a new transfer be taken while a
// result waits; decoding holds only when a second result is ready before the first
// has been taken. sub_count is written through the cfg_ port and sampled at headers.
`include "packed_delta_channel_decoder_core_defines.svh"
module packed_delta_channel_decoder_core
    import pdcd_pkg::*;
#(
    parameter int MAX_SUB = MAX_SUB_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first,
    input  logic signed [15:0] s_base_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_channel_value,
    output logic        m_abandoned
);

    // Sequencer state and decode state
    state_t      state_reg, state_next;
    logic [31:0] win_reg, win_next;          // pending bits, oldest at bit 31
    logic [5:0]  count_reg, count_next;      // number of pending bits
    logic [15:0] run_left_reg, run_left_next;
    logic [4:0]  cw_reg, cw_next;            // remembered code width
    logic [15:0] bias_reg, bias_next;        // remembered code bias
    logic [15:0] rsum_reg, rsum_next;
    logic [15:0] acc_reg, acc_next;
    logic        first_pend_reg, first_pend_next;
    logic [3:0]  codes_reg, codes_next;
    logic        active_reg, active_next;
    logic [3:0]  sub_reg, sub_next;

    // Captured transfer and decoded code
    logic [7:0]  byte_reg, byte_next;
    logic [15:0] base_reg, base_next;
    logic [15:0] val_reg, val_next;
    logic        is_end_reg, is_end_next;
    logic [5:0]  drop_reg, drop_next;

    // Output register
    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_value_reg, m_value_next;
    logic        m_abandoned_reg, m_abandoned_next;

    // Shared shifter
    shift_req_t  sh_req;
    logic [31:0] sh_out;

    // Code decode of the window head
    logic [3:0]  sel;
    logic [3:0]  nib;
    logic [4:0]  eff_w;
    logic [5:0]  k;
    logic [4:0]  fw;
    logic [5:0]  need;
    logic        use_reg_bias;
    logic        is_end_c;
    logic [15:0] bias_c;
    logic [15:0] field;
    logic [15:0] val_c;
    logic        complete;

    // Accumulate step
    logic [15:0] acc_step;
    logic [15:0] rsum_step;
    logic [3:0]  codes_step;
    logic        done;
    logic        out_free;
    logic [3:0]  sub_sat;

    pdcd_shift_unit u_shift (
        .req    (sh_req),
        .result (sh_out)
    );

    assign cfg_ready       = 1'b1;
    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_channel_value = m_value_reg;
    assign m_abandoned     = m_abandoned_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign sub_sat  = (sub_reg > 4'(MAX_SUB)) ? 4'(MAX_SUB) : sub_reg;

    assign sel   = win_reg[31:28];
    assign nib   = win_reg[27:24];
    assign eff_w = (cw_reg == WIDTH_END) ? 5'd0 : cw_reg;

    // Locate the next code: field offset, field width, end flag
    always_comb begin
        k            = 6'd4;
        fw           = 5'd0;
        use_reg_bias = 1'b0;
        is_end_c     = 1'b0;
        if (run_left_reg != 16'd0) begin
            k            = 6'd0;
            fw           = eff_w;
            use_reg_bias = 1'b1;
            is_end_c     = (cw_reg == WIDTH_END);
        end else begin
            case (sel)
                SEL_REPEAT: begin
                    k            = 6'd8;
                    fw           = eff_w;
                    use_reg_bias = 1'b1;
                    is_end_c     = (cw_reg == WIDTH_END);
                end
                SEL_END: begin
                    is_end_c = 1'b1;
                end
                SEL_RAW: begin
                    fw = 5'd16;
                end
                default: begin
                    // field width rounds the selector up to even
                    fw = ({1'b0, sel} + 5'd1) & 5'b11110;
                end
            endcase
        end
    end

    assign need     = k + 6'(fw);
    assign complete = (count_reg >= need);
    assign bias_c   = use_reg_bias ? bias_reg : bias_of(sel);
    assign field    = sh_out[15:0] & low_mask16(fw);
    assign val_c    = (fw == 5'd0) ? 16'd0 : (bias_c + field);

    // Route the shifter: append a byte, extract a field, or drop consumed bits
    always_comb begin
        case (state_reg)
            ST_APPEND: begin
                sh_req.data = {byte_reg, 24'd0};
                sh_req.amt  = count_reg;
                sh_req.left = 1'b0;
            end
            ST_DROP: begin
                sh_req.data = win_reg;
                sh_req.amt  = drop_reg;
                sh_req.left = 1'b1;
            end
            default: begin
                sh_req.data = win_reg;
                sh_req.amt  = 6'd32 - need;
                sh_req.left = 1'b0;
            end
        endcase
    end

    // Fold one decoded code into the channel value
    always_comb begin
        acc_step   = acc_reg;
        rsum_step  = rsum_reg;
        codes_step = codes_reg;
        done       = 1'b0;
        if (first_pend_reg) begin
            acc_step = acc_reg + val_reg;
            done     = (codes_reg == 4'd0);
        end else if (is_end_reg) begin
            done = 1'b1;
        end else begin
            rsum_step  = rsum_reg + val_reg;
            acc_step   = acc_reg + rsum_step;
            codes_step = codes_reg - 4'd1;
            done       = (codes_reg == 4'd1);
        end
    end

    // Next state and outputs
    always_comb begin
        state_next       = state_reg;
        win_next         = win_reg;
        count_next       = count_reg;
        run_left_next    = run_left_reg;
        cw_next          = cw_reg;
        bias_next        = bias_reg;
        rsum_next        = rsum_reg;
        acc_next         = acc_reg;
        first_pend_next  = first_pend_reg;
        codes_next       = codes_reg;
        active_next      = active_reg;
        sub_next         = sub_reg;
        byte_next        = byte_reg;
        base_next        = base_reg;
        val_next         = val_reg;
        is_end_next      = is_end_reg;
        drop_next        = drop_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_value_next     = m_value_reg;
        m_abandoned_next = m_abandoned_reg;

        if (cfg_valid && cfg_ready) begin
            sub_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    byte_next = s_data_byte;
                    base_next = s_base_value;
                    if (s_first) begin
                        state_next = ST_HDR;
                    end else if (active_reg) begin
                        state_next = ST_APPEND;
                    end
                    // drop a data byte that arrives with no channel open
                end
            end
            ST_HDR: begin
                // hold until the abandoned result has a slot
                if (!active_reg || out_free) begin
                    if (active_reg) begin
                        m_valid_next     = 1'b1;
                        m_value_next     = acc_reg;
                        m_abandoned_next = 1'b1;
                    end
                    win_next        = {byte_reg[1:0], 30'd0};
                    count_next      = 6'd2;
                    run_left_next   = 16'd0;
                    rsum_next       = 16'd0;
                    acc_next        = base_reg;
                    first_pend_next = 1'b1;
                    codes_next      = sub_sat;
                    active_next     = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_APPEND: begin
                win_next   = win_reg | sh_out;
                count_next = count_reg + 6'd8;
                state_next = ST_FIELD;
            end
            ST_FIELD: begin
                if (complete) begin
                    val_next    = val_c;
                    is_end_next = is_end_c;
                    drop_next   = need;
                    if (run_left_reg != 16'd0) begin
                        run_left_next = run_left_reg - 16'd1;
                    end else begin
                        case (sel)
                            SEL_REPEAT: begin
                                run_left_next = {12'd0, nib} - 16'd1;
                            end
                            SEL_END: begin
                                cw_next   = WIDTH_END;
                                bias_next = 16'd0;
                            end
                            default: begin
                                cw_next   = fw;
                                bias_next = bias_c;
                            end
                        endcase
                    end
                    state_next = ST_DROP;
                end else begin
                    // wait for more bits
                    state_next = ST_IDLE;
                end
            end
            ST_DROP: begin
                if (done) begin
                    if (out_free) begin
                        m_valid_next     = 1'b1;
                        m_value_next     = acc_step;
                        m_abandoned_next = 1'b0;
                        acc_next         = acc_step;
                        rsum_next        = rsum_step;
                        codes_next       = codes_step;
                        first_pend_next  = 1'b0;
                        active_next      = 1'b0;
                        win_next         = 32'd0;
                        count_next       = 6'd0;
                        state_next       = ST_IDLE;
                    end
                end else begin
                    acc_next        = acc_step;
                    rsum_next       = rsum_step;
                    codes_next      = codes_step;
                    first_pend_next = 1'b0;
                    win_next        = sh_out;
                    count_next      = count_reg - drop_reg;
                    state_next      = ST_FIELD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            win_reg        <= '0;
            count_reg      <= '0;
            run_left_reg   <= '0;
            cw_reg         <= '0;
            bias_reg       <= '0;
            rsum_reg       <= '0;
            acc_reg        <= '0;
            first_pend_reg <= 1'b0;
            codes_reg      <= '0;
            active_reg     <= 1'b0;
            sub_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            win_reg        <= win_next;
            count_reg      <= count_next;
            run_left_reg   <= run_left_next;
            cw_reg         <= cw_next;
            bias_reg       <= bias_next;
            rsum_reg       <= rsum_next;
            acc_reg        <= acc_next;
            first_pend_reg <= first_pend_next;
            codes_reg      <= codes_next;
            active_reg     <= active_next;
            sub_reg        <= sub_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        byte_reg        <= byte_next;
        base_reg        <= base_next;
        val_reg         <= val_next;
        is_end_reg      <= is_end_next;
        drop_reg        <= drop_next;
        m_value_reg     <= m_value_next;
        m_abandoned_reg <= m_abandoned_next;
    end

    `PDCD_NEVER(a_window_fits, count_reg > 6'd31, "bit window overflow")
    `PDCD_ASSERT(a_idle_window_empty, !active_reg |-> count_reg == 6'd0, "bits left idle")
    `PDCD_ASSERT(a_decode_needs_channel, (state_reg == ST_FIELD || state_reg == ST_DROP) |-> active_reg, "no channel")

endmodule
